[rtl/json_string_unescape_utf8_defines.svh]
// Assertion macros shared by the JSON string unescape checker.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/jsu_pkg.sv]
// Types, codes and decode helpers for the JSON string unescape block.
package jsu_pkg;

  // Scan state of the decoder.
  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_STR    = 3'd1,
    M_ESC    = 3'd2,
    M_HEX    = 3'd3,
    M_HI     = 3'd4,
    M_HI_ESC = 3'd5,
    M_HI_HEX = 3'd6
  } mode_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_BYTE  = 3'd0,
    ST_DONE  = 3'd1,
    ST_NOQ   = 3'd2,
    ST_CTRL  = 3'd3,
    ST_TRUNC = 3'd4,
    ST_BADU  = 3'd5,
    ST_UNK   = 3'd6,
    ST_UNTRM = 3'd7
  } status_t;

  // What follows the optional high-surrogate prefix in a result list.
  typedef enum logic [1:0] {
    BODY_NONE = 2'd0,
    BODY_ONE  = 2'd1,
    BODY_CP   = 2'd2
  } body_kind_t;

  typedef struct packed {
    body_kind_t  kind;
    logic [7:0]  data;
    status_t     stat;
    mode_t       mode;
  } action_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned HIGH_BYTES  = 3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // One byte of the string body.
  function automatic action_t body_action(logic [7:0] c);
    action_t a;
    a.kind = BODY_ONE;
    a.data = 8'h00;
    a.stat = ST_BYTE;
    a.mode = M_STR;
    if (c == CH_QUOTE) begin
      a.stat = ST_DONE;
      a.mode = M_IDLE;
    end else if (c == CH_BSLASH) begin
      a.kind = BODY_NONE;
      a.mode = M_ESC;
    end else if (c < CTRL_LIMIT) begin
      a.stat = ST_CTRL;
      a.mode = M_IDLE;
    end else begin
      a.data = c;
    end
    return a;
  endfunction

  // The byte after a backslash. A 'u' opens a hex escape.
  function automatic action_t escape_action(logic [7:0] c);
    action_t a;
    a.kind = BODY_ONE;
    a.data = 8'h00;
    a.stat = ST_BYTE;
    a.mode = M_STR;
    case (c)
      CH_QUOTE:  a.data = CH_QUOTE;
      CH_BSLASH: a.data = CH_BSLASH;
      CH_SLASH:  a.data = CH_SLASH;
      CH_LOW_B:  a.data = 8'h08;
      CH_LOW_F:  a.data = 8'h0C;
      CH_LOW_N:  a.data = 8'h0A;
      CH_LOW_R:  a.data = 8'h0D;
      CH_LOW_T:  a.data = 8'h09;
      CH_LOW_U: begin
        a.kind = BODY_NONE;
        a.mode = M_HEX;
      end
      default: begin
        a.stat = ST_UNK;
        a.mode = M_IDLE;
      end
    endcase
    return a;
  endfunction

  // Hex digit in either case.
  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.value = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // UTF-8 encoding of a code point below 0x110000.
  function automatic utf8_t utf8_encode(logic [20:0] cp);
    utf8_t u;
    u.bytes = '0;
    if (cp < 21'h80) begin
      u.len = 3'd1;
      u.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      u.len = 3'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.len = 3'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.len = 3'd4;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

[rtl/json_string_unescape_utf8.sv]
// Streaming JSON string literal decoder that emits UTF-8 bytes.
//
//   channel  handshake           payload                 direction
//   input    in_valid/in_stall   in_byte, input_end      into the block
//   output   out_valid/out_stall out_byte, status, last  out of the block
//
// An input transfer is decoded in the cycle it is taken; its 0 to 6 results
// go into a six-entry buffer and leave one per cycle while out_stall is low.
// The next input is taken as the last result leaves, so unstalled items with
// at most one result flow at one per clock and longer lists hold the input.
// Reset (rst, synchronous) returns to idle, awaiting an opening quote, with an
// empty buffer. An output stall holds the current result and the input.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       input_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] status,
  output logic       last
);
  import jsu_pkg::*;

  // Decoder state.
  mode_t       mode, mode_next;
  logic [15:0] hex_value, hex_value_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic [9:0]  pend_high, pend_high_next;

  // Result buffer.
  logic [7:0] res_byte [MAX_RESULTS];
  logic [2:0] res_stat [MAX_RESULTS];
  logic [2:0] res_cnt;
  logic [2:0] res_idx;

  // Decode outputs for the item at the port.
  logic        hi_en;
  action_t     act;
  logic [20:0] cp;
  utf8_t       enc;
  hex_t        hd;
  logic [15:0] hv;
  logic [2:0]  pre;
  logic [2:0]  body_len;
  logic [2:0]  n;
  logic [2:0]  j;
  logic [7:0]  slot_byte [MAX_RESULTS];
  logic [2:0]  slot_stat [MAX_RESULTS];
  logic [7:0]  high_byte [HIGH_BYTES];

  logic in_take;
  logic out_take;

  // Handshake: take new input once the buffer is empty or drains this cycle.
  assign out_valid = (res_idx != res_cnt);
  assign last      = out_valid && (res_idx == res_cnt - 3'd1);
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = out_valid && !(out_take && last);
  assign in_take   = in_valid && !in_stall;
  assign out_byte  = out_valid ? res_byte[res_idx] : 8'h00;
  assign status    = out_valid ? res_stat[res_idx] : ST_BYTE;

  // The pending high surrogate, 0xD800 plus pend_high, always encodes as three bytes.
  assign high_byte[0] = 8'hED;
  assign high_byte[1] = {4'b1010, pend_high[9:6]};
  assign high_byte[2] = {2'b10, pend_high[5:0]};

  assign hd = hex_digit(in_byte);
  assign hv = {hex_value[11:0], hd.value};

  // Next state and the shape of the result list.
  always_comb begin
    mode_next      = mode;
    hex_value_next = hex_value;
    hex_cnt_next   = hex_cnt;
    pend_high_next = pend_high;
    hi_en          = 1'b0;
    act            = '{kind: BODY_NONE, data: 8'h00, stat: ST_BYTE, mode: M_IDLE};
    cp             = '0;
    unique case (mode)
      M_STR: begin
        if (input_end) begin
          act = '{kind: BODY_ONE, data: 8'h00, stat: ST_UNTRM, mode: M_IDLE};
        end else begin
          act = body_action(in_byte);
        end
        mode_next = act.mode;
      end
      M_ESC: begin
        if (input_end) begin
          act = '{kind: BODY_ONE, data: 8'h00, stat: ST_TRUNC, mode: M_IDLE};
        end else begin
          act = escape_action(in_byte);
        end
        mode_next = act.mode;
        if (act.mode == M_HEX) begin
          hex_value_next = '0;
          hex_cnt_next   = '0;
        end
      end
      M_HEX, M_HI_HEX: begin
        if (input_end || !hd.ok) begin
          hi_en     = (mode == M_HI_HEX);
          act       = '{kind: BODY_ONE, data: 8'h00, stat: ST_BADU, mode: M_IDLE};
          mode_next = M_IDLE;
        end else if (hex_cnt != 2'd3) begin
          hex_value_next = hv;
          hex_cnt_next   = hex_cnt + 2'd1;
        end else begin
          hex_value_next = hv;
          hex_cnt_next   = '0;
          if (mode == M_HI_HEX && hv >= LOW_FIRST && hv <= LOW_LAST) begin
            // Surrogate pair joins into one supplementary code point.
            cp        = SUPP_BASE + {1'b0, pend_high, hv[9:0]};
            act.kind  = BODY_CP;
            mode_next = M_STR;
          end else begin
            hi_en = (mode == M_HI_HEX);
            if (hv >= HIGH_FIRST && hv <= HIGH_LAST) begin
              pend_high_next = hv[9:0];
              mode_next      = M_HI;
            end else begin
              cp        = {5'b0, hv};
              act.kind  = BODY_CP;
              mode_next = M_STR;
            end
          end
        end
      end
      M_HI: begin
        if (!input_end && in_byte == CH_BSLASH) begin
          mode_next = M_HI_ESC;
        end else begin
          hi_en = 1'b1;
          if (input_end) begin
            act = '{kind: BODY_ONE, data: 8'h00, stat: ST_UNTRM, mode: M_IDLE};
          end else begin
            act = body_action(in_byte);
          end
          mode_next = act.mode;
        end
      end
      M_HI_ESC: begin
        if (!input_end && in_byte == CH_LOW_U) begin
          hex_value_next = '0;
          hex_cnt_next   = '0;
          mode_next      = M_HI_HEX;
        end else begin
          hi_en = 1'b1;
          if (input_end) begin
            act = '{kind: BODY_ONE, data: 8'h00, stat: ST_TRUNC, mode: M_IDLE};
          end else begin
            act = escape_action(in_byte);
          end
          mode_next = act.mode;
        end
      end
      default: begin
        // Idle, and any unused code, waits for the opening quote.
        if (!input_end && in_byte == CH_QUOTE) begin
          mode_next = M_STR;
        end else begin
          act       = '{kind: BODY_ONE, data: 8'h00, stat: ST_NOQ, mode: M_IDLE};
          mode_next = M_IDLE;
        end
      end
    endcase
  end

  assign enc = utf8_encode(cp);

  // Lay the optional high-surrogate prefix and the body into result slots.
  always_comb begin
    pre = hi_en ? 3'(HIGH_BYTES) : 3'd0;
    case (act.kind)
      BODY_ONE: body_len = 3'd1;
      BODY_CP:  body_len = enc.len;
      default:  body_len = 3'd0;
    endcase
    n = pre + body_len;
    j = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      j = 3'(i) - pre;
      slot_byte[i] = 8'h00;
      slot_stat[i] = ST_BYTE;
      if (hi_en && i < HIGH_BYTES) begin
        slot_byte[i] = high_byte[i];
      end else if (act.kind == BODY_ONE) begin
        slot_byte[i] = act.data;
        slot_stat[i] = act.stat;
      end else if (j < 3'd4) begin
        slot_byte[i] = enc.bytes[j[1:0]];
      end
    end
  end

  // Control state and buffer pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      hex_value <= '0;
      hex_cnt   <= '0;
      pend_high <= '0;
      res_cnt   <= '0;
      res_idx   <= '0;
    end else if (in_take) begin
      mode      <= mode_next;
      hex_value <= hex_value_next;
      hex_cnt   <= hex_cnt_next;
      pend_high <= pend_high_next;
      res_cnt   <= n;
      res_idx   <= '0;
    end else if (out_take) begin
      res_idx <= res_idx + 3'd1;
    end
  end

  // Result payload, loaded whole on each input transfer.
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_byte[i] <= slot_byte[i];
        res_stat[i] <= slot_stat[i];
      end
    end
  end

endmodule

[rtl/jsu_checker.sv]
// Port-level checker for the JSON string unescape block, with its bind.
`include "json_string_unescape_utf8_defines.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       input_end,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [2:0] status,
  input logic       last
);
  import jsu_pkg::*;

  // A stalled input transfer keeps its payload.
  `JSU_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(in_byte) && $stable(input_end), "stalled input changed")

  // A stalled result holds.
  `JSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_byte) && $stable(status) && $stable(last),
    "stalled result changed")

  // Completion and errors always close the results of an item.
  `JSU_ASSERT_NOW(a_end_is_last, out_valid && status != ST_BYTE,
    last && out_byte == 8'h00, "non-byte result not final or carries data")

  // Input only waits while results are still queued.
  `JSU_ASSERT_NOW(a_stall_cause, in_stall, out_valid, "input stalled with no result pending")

  // Once the final result leaves and nothing new arrives, the output goes quiet.
  `JSU_ASSERT_NEXT(a_drain, out_valid && !out_stall && last && !(in_valid && !in_stall),
    !out_valid, "result shown after final transfer")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
